[rtl/hctb_pkg.sv]
// ----------------------------------------------------------------------------
// hctb_pkg
// shared constants, types and sequencer states of the code table builder
// ----------------------------------------------------------------------------
package hctb_pkg;

   localparam int SymBits   = 8;
   localparam int AlphaSize = 256;
   localparam int NodeBits  = 9;
   localparam int NodeTotal = 2 * AlphaSize - 1;
   localparam int CountBits = 24;
   localparam int WeightBits = 32;
   localparam int LenBits   = 6;
   localparam int CodeBits  = 48;
   localparam int MaxLen    = 48;
   localparam int DistBits  = 9;
   localparam int WalkLenBits = 9;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BUILD = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_FLOYD_NEXT,
      ST_SD_RD_KIDS,
      ST_SD_RD_W,
      ST_SD_CMP,
      ST_SINGLE,
      ST_POP_START,
      ST_POP_DONE,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_PUSH_RD,
      ST_PUSH_WT,
      ST_PUSH_CMP,
      ST_WALK_RD,
      ST_WALK_KID,
      ST_WALK_WR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [NodeBits-1:0] pos;
      logic [NodeBits-1:0] size;
   } sift_req_type;

endpackage

[rtl/hctb_sift_unit.sv]
// ----------------------------------------------------------------------------
// hctb_sift_unit
// shared weight compare: picks the smaller child and decides a swap
// ----------------------------------------------------------------------------
module hctb_sift_unit (
   input  logic [hctb_pkg::WeightBits-1:0] w_parent,
   input  logic [hctb_pkg::WeightBits-1:0] w_left,
   input  logic [hctb_pkg::WeightBits-1:0] w_right,
   input  logic                            has_right,
   output logic                            pick_right,
   output logic                            do_swap
);
   import hctb_pkg::*;

   logic [WeightBits-1:0] w_kid;

   always_comb begin
      pick_right = has_right && (w_right < w_left);
      w_kid      = pick_right ? w_right : w_left;
      do_swap    = w_parent > w_kid;
   end
endmodule

[rtl/huffman_code_table_builder_core.sv]
// ----------------------------------------------------------------------------
// huffman_code_table_builder_core
// count store, min-heap tree build and code table under one sequencer
// ----------------------------------------------------------------------------
// write passes through ST_DONE, read through ST_READ and ST_DONE; busy meanwhile
// build: table clear by valid bits, a read and a write state per symbol scan,
//   then read, read and compare states per sift or push level and read, kid,
//   write, kid, write states per tree node walk; only sift uses the compare unit
// one item at a time; busy falls as the result strobe rises; writes give no strobe
// reset: synchronous, clears counts and code table by valid bits
// ----------------------------------------------------------------------------
module huffman_code_table_builder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [hctb_pkg::SymBits-1:0]       req_symbol,
   input  logic [hctb_pkg::CountBits-1:0]     req_count,
   output logic                               rsp_strobe,
   output logic [hctb_pkg::SymBits-1:0]       rsp_code_symbol,
   output logic [hctb_pkg::LenBits-1:0]       rsp_code_length,
   output logic [hctb_pkg::CodeBits-1:0]      rsp_code_bits,
   output logic [hctb_pkg::DistBits-1:0]      rsp_distinct_symbols
);
   import hctb_pkg::*;

   // memories
   logic [CountBits-1:0]  cnt_mem  [AlphaSize];
   logic [AlphaSize-1:0]  cnt_vld_ff;
   logic [WeightBits-1:0] wt_mem   [NodeTotal];
   logic [2*NodeBits-1:0] kid_mem  [NodeTotal];
   logic [NodeBits-1:0]   heap_mem [AlphaSize];
   logic [LenBits+CodeBits-1:0] tab_mem [AlphaSize];
   logic [AlphaSize-1:0]  tab_vld_ff;
   logic [WalkLenBits+CodeBits-1:0] walk_mem [NodeTotal];

   state_type state_ff, state_in;

   logic [SymBits-1:0]    sym_ff;
   logic [1:0]            op_ff;
   logic [NodeBits-1:0]   i_ff;       // scan index / walk node
   logic [NodeBits-1:0]   size_ff;
   logic [NodeBits-1:0]   pos_ff;
   logic [NodeBits-1:0]   floyd_ff;
   logic [NodeBits-1:0]   next_ff;
   logic [NodeBits-1:0]   a_ff;
   logic [NodeBits-1:0]   b_ff;
   logic                  second_ff;
   logic                  floyd_mode_ff;
   logic [NodeBits-1:0]   sp_ff, sl_ff, sr_ff;   // slot contents
   logic [WeightBits-1:0] wp_ff, wl_ff, wr_ff;
   logic [DistBits-1:0]   present_ff;
   logic                  side_ff;
   logic [WalkLenBits+CodeBits-1:0] wn_ff;
   logic [2*NodeBits-1:0] kids_ff;
   logic [LenBits+CodeBits-1:0] tab_rd_ff;
   logic                  tab_rd_vld_ff;
   logic [CountBits-1:0]  cnt_rd_ff;
   logic                  cnt_rd_vld_ff;

   logic pick_right, do_swap;
   logic [NodeBits-1:0] lk, rk, kid_pos;
   logic [NodeBits-1:0] last_pos, floyd_pos;
   logic has_left, has_right;

   assign lk        = NodeBits'({pos_ff, 1'b1});
   assign rk        = lk + NodeBits'(1);
   assign has_left  = ({1'b0, pos_ff, 1'b1} < {2'b0, size_ff});
   assign has_right = ({1'b0, pos_ff, 1'b0} + (NodeBits+2)'(2)) < {2'b0, size_ff};
   assign kid_pos   = pick_right ? rk : lk;
   assign last_pos  = size_ff - NodeBits'(1);
   assign floyd_pos = floyd_ff - NodeBits'(1);

   hctb_sift_unit u_sift (
      .w_parent  (wp_ff),
      .w_left    (wl_ff),
      .w_right   (wr_ff),
      .has_right (has_right),
      .pick_right(pick_right),
      .do_swap   (do_swap)
   );

   // push parent index
   logic [NodeBits-1:0] par;
   assign par = (pos_ff - NodeBits'(1)) >> 1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) begin
            case (req_operation)
               OP_WRITE: state_in = ST_DONE;
               OP_BUILD: state_in = ST_CLEAR;
               OP_READ:  state_in = ST_READ;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_CLEAR:      state_in = ST_LOAD_RD;
         ST_LOAD_RD:    state_in = ST_LOAD_WR;
         ST_LOAD_WR:    state_in = (i_ff == NodeBits'(AlphaSize - 1)) ?
                                   ST_FLOYD_NEXT : ST_LOAD_RD;
         ST_FLOYD_NEXT: begin
            if (size_ff == '0)          state_in = ST_DONE;
            else if (floyd_ff == '0)
               state_in = (size_ff == NodeBits'(1)) ? ST_SINGLE : ST_POP_START;
            else                        state_in = ST_SD_RD_KIDS;
         end
         ST_SD_RD_KIDS: state_in = has_left ? ST_SD_RD_W : ST_POP_DONE;
         ST_SD_RD_W:    state_in = ST_SD_CMP;
         ST_SD_CMP:     state_in = do_swap ? ST_SD_RD_KIDS : ST_POP_DONE;
         ST_SINGLE:     state_in = ST_DONE;
         ST_POP_START:  state_in = ST_SD_RD_KIDS;
         ST_POP_DONE: begin
            if (floyd_mode_ff)   state_in = ST_FLOYD_NEXT;
            else if (!second_ff) state_in = ST_POP_START;
            else                 state_in = ST_MERGE_RD;
         end
         ST_MERGE_RD:   state_in = ST_MERGE_WR;
         ST_MERGE_WR:   state_in = ST_PUSH_RD;
         ST_PUSH_RD:    state_in = ST_PUSH_WT;
         ST_PUSH_WT:    state_in = ST_PUSH_CMP;
         ST_PUSH_CMP: begin
            if (pos_ff != '0 && wl_ff < wr_ff) state_in = ST_PUSH_RD;
            else state_in = (size_ff == NodeBits'(1)) ? ST_WALK_RD : ST_POP_START;
         end
         ST_WALK_RD:    state_in = ST_WALK_KID;
         ST_WALK_KID:   state_in = ST_WALK_WR;
         ST_WALK_WR:    state_in = side_ff ?
                           ((i_ff == NodeBits'(AlphaSize)) ? ST_DONE : ST_WALK_RD)
                           : ST_WALK_KID;
         ST_READ:       state_in = ST_DONE;
         ST_DONE:       state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
   end

   logic [NodeBits-1:0] kid_sel;
   logic [WalkLenBits+CodeBits-1:0] wc;
   assign kid_sel = side_ff ? kids_ff[NodeBits-1:0] : kids_ff[2*NodeBits-1:NodeBits];
   assign wc = {wn_ff[WalkLenBits+CodeBits-1:CodeBits] + WalkLenBits'(1),
                wn_ff[CodeBits-2:0], side_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_vld_ff <= '0;
         tab_vld_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= (state_ff == ST_DONE) &&
                       ((op_ff == OP_BUILD) || (op_ff == OP_READ));
         case (state_ff)
            ST_IDLE: if (start) begin
               op_ff  <= req_operation;
               sym_ff <= req_symbol;
               cnt_rd_ff     <= cnt_mem[req_symbol];
               cnt_rd_vld_ff <= 1'b0;
               tab_rd_ff     <= tab_mem[req_symbol];
               tab_rd_vld_ff <= tab_vld_ff[req_symbol];
               if (req_operation == OP_WRITE) begin
                  cnt_mem[req_symbol]    <= req_count;
                  cnt_vld_ff[req_symbol] <= 1'b1;
               end
            end
            ST_CLEAR: begin
               tab_vld_ff <= '0;
               i_ff       <= '0;
               size_ff    <= '0;
               present_ff <= '0;
            end
            ST_LOAD_RD: begin
               cnt_rd_ff     <= cnt_mem[i_ff[SymBits-1:0]];
               cnt_rd_vld_ff <= cnt_vld_ff[i_ff[SymBits-1:0]];
            end
            ST_LOAD_WR: begin
               if (cnt_rd_vld_ff && cnt_rd_ff != '0) begin
                  wt_mem[i_ff]                  <= WeightBits'(cnt_rd_ff);
                  heap_mem[size_ff[SymBits-1:0]] <= i_ff;
                  size_ff    <= size_ff + NodeBits'(1);
                  present_ff <= present_ff + DistBits'(1);
               end
               i_ff <= i_ff + NodeBits'(1);
               floyd_mode_ff <= 1'b1;
               floyd_ff <= NodeBits'(((size_ff + ((cnt_rd_vld_ff && cnt_rd_ff != '0) ?
                           NodeBits'(1) : NodeBits'(0)) - NodeBits'(1)) >> 1)
                           + NodeBits'(1));
            end
            ST_FLOYD_NEXT: begin
               if (floyd_ff != '0) begin
                  floyd_ff <= floyd_pos;
                  pos_ff   <= floyd_pos;
                  sp_ff    <= heap_mem[floyd_pos[SymBits-1:0]];
               end else begin
                  floyd_mode_ff <= 1'b0;
                  second_ff     <= 1'b1;
                  next_ff       <= NodeBits'(AlphaSize);
               end
            end
            ST_SD_RD_KIDS: begin
               wp_ff <= wt_mem[sp_ff];
               sl_ff <= heap_mem[lk[SymBits-1:0]];
               sr_ff <= heap_mem[rk[SymBits-1:0]];
            end
            ST_SD_RD_W: begin
               wl_ff <= wt_mem[sl_ff];
               wr_ff <= wt_mem[sr_ff];
            end
            ST_SD_CMP: if (do_swap) begin
               heap_mem[pos_ff[SymBits-1:0]] <= pick_right ? sr_ff : sl_ff;
               pos_ff <= kid_pos;
            end
            ST_SINGLE: begin
               tab_mem[sp_ff[SymBits-1:0]]    <= {LenBits'(1), CodeBits'(0)};
               tab_vld_ff[sp_ff[SymBits-1:0]] <= 1'b1;
            end
            ST_POP_START: begin
               second_ff <= !second_ff;
               if (second_ff) a_ff <= heap_mem[0];
               else           b_ff <= heap_mem[0];
               sp_ff   <= heap_mem[last_pos[SymBits-1:0]];
               size_ff <= last_pos;
               pos_ff  <= '0;
            end
            ST_POP_DONE: begin
               heap_mem[pos_ff[SymBits-1:0]] <= sp_ff;
            end
            ST_MERGE_RD: begin
               wl_ff <= wt_mem[a_ff];
               wr_ff <= wt_mem[b_ff];
            end
            ST_MERGE_WR: begin
               wt_mem[next_ff]  <= wl_ff + wr_ff;
               kid_mem[next_ff] <= {a_ff, b_ff};
               wl_ff  <= wl_ff + wr_ff;
               pos_ff <= size_ff;
               size_ff <= size_ff + NodeBits'(1);
            end
            ST_PUSH_RD: begin
               sr_ff <= heap_mem[par[SymBits-1:0]];
            end
            ST_PUSH_WT: begin
               wr_ff <= wt_mem[sr_ff];
            end
            ST_PUSH_CMP: begin
               if (pos_ff != '0 && wl_ff < wr_ff) begin
                  heap_mem[pos_ff[SymBits-1:0]] <= sr_ff;
                  pos_ff <= par;
               end else begin
                  heap_mem[pos_ff[SymBits-1:0]] <= next_ff;
                  if (size_ff == NodeBits'(1)) begin
                     walk_mem[next_ff] <= '0;
                     i_ff <= next_ff;
                  end
                  next_ff <= next_ff + NodeBits'(1);
               end
            end
            ST_WALK_RD: begin
               kids_ff <= kid_mem[i_ff];
               wn_ff   <= walk_mem[i_ff];
               side_ff <= 1'b0;
            end
            ST_WALK_KID: ;
            ST_WALK_WR: begin
               walk_mem[kid_sel] <= wc;
               if (kid_sel < NodeBits'(AlphaSize) &&
                   wc[WalkLenBits+CodeBits-1:CodeBits] <= WalkLenBits'(MaxLen)) begin
                  tab_mem[kid_sel[SymBits-1:0]] <=
                     {wc[CodeBits+LenBits-1:CodeBits], wc[CodeBits-1:0]};
                  tab_vld_ff[kid_sel[SymBits-1:0]] <= 1'b1;
               end
               side_ff <= !side_ff;
               if (side_ff) i_ff <= i_ff - NodeBits'(1);
            end
            ST_READ: ;
            ST_DONE: begin
               if (op_ff == OP_BUILD) begin
                  rsp_code_symbol      <= '0;
                  rsp_code_length      <= '0;
                  rsp_code_bits        <= '0;
                  rsp_distinct_symbols <= present_ff;
               end else begin
                  rsp_code_symbol      <= sym_ff;
                  rsp_code_length      <= tab_rd_vld_ff ?
                                          tab_rd_ff[LenBits+CodeBits-1:CodeBits] : '0;
                  rsp_code_bits        <= tab_rd_vld_ff ? tab_rd_ff[CodeBits-1:0] : '0;
                  rsp_distinct_symbols <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

[rtl/hctb_checker.sv]
// ----------------------------------------------------------------------------
// hctb_checker
// port level checks of the code table builder
// ----------------------------------------------------------------------------
module hctb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [hctb_pkg::LenBits-1:0]  rsp_code_length,
   input logic [hctb_pkg::CodeBits-1:0] rsp_code_bits,
   input logic [hctb_pkg::DistBits-1:0] rsp_distinct_symbols
);
   import hctb_pkg::*;

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_code_length <= LenBits'(MaxLen)) else $error("length");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe");
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_code_length == '0 |-> rsp_code_bits == '0) else $error("bits");
   a_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_distinct_symbols != '0 |-> rsp_code_length == '0)
      else $error("dist");
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe) else $error("accept");
endmodule

bind huffman_code_table_builder_core hctb_checker u_hctb_checker (.*);

[verif/huffman_code_table_builder_core_test.sv]
// ----------------------------------------------------------------------------
// huffman_code_table_builder_core_test
// Drives count writes, build commands and code reads into the core. A
// built-in min-heap tree builder predicts every read and build response.
// Responses are compared field by field, in order, with the expected queue.
// ----------------------------------------------------------------------------
module huffman_code_table_builder_core_test;
   import hctb_pkg::*;

   typedef struct {
      op_type      op;
      logic [7:0]  sym;
      logic [23:0] cnt;
      bit          drain;
   } item_type;

   typedef struct {
      logic [7:0]  sym;
      logic [5:0]  len;
      logic [47:0] bits;
      logic [8:0]  distinct;
   } code_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_operation = 0;
   logic [7:0]  req_symbol = 0;
   logic [23:0] req_count = 0;
   logic        rsp_strobe;
   logic [7:0]  rsp_code_symbol;
   logic [5:0]  rsp_code_length;
   logic [47:0] rsp_code_bits;
   logic [8:0]  rsp_distinct_symbols;

   huffman_code_table_builder_core dut (.*);

   always #6 clock = ~clock;

   item_type pending_items[$];
   code_type expected_codes[$];
   item_type cur;
   int       errors = 0;
   int       accepted = 0;
   int       idle_pct;
   bit       launch;

   // builder state
   logic [23:0]     counts[256];
   longint unsigned weight[511];
   int              kids[511][2];
   int              heap[256];
   int              heap_n;
   int              walk_len[511];
   longint unsigned walk_bits[511];
   logic [5:0]      table_len[256];
   logic [47:0]     table_bits[256];

   // generator shadow of counts
   logic [23:0]     gen_counts[256];
   int              total = 0;

   function automatic void sift_down(int pos);
      int k, t;
      while (2 * pos + 1 < heap_n) begin
         k = 2 * pos + 1;
         if (k + 1 < heap_n && weight[heap[k + 1]] < weight[heap[k]]) k++;
         if (weight[heap[pos]] <= weight[heap[k]]) break;
         t = heap[pos]; heap[pos] = heap[k]; heap[k] = t;
         pos = k;
      end
   endfunction

   function automatic int pop_min();
      int top;
      top = heap[0];
      heap[0] = heap[heap_n - 1];
      heap_n--;
      sift_down(0);
      return top;
   endfunction

   function automatic void push_node(int node);
      int i;
      i = heap_n;
      heap_n++;
      while (i != 0 && weight[node] < weight[heap[(i - 1) / 2]]) begin
         heap[i] = heap[(i - 1) / 2];
         i = (i - 1) / 2;
      end
      heap[i] = node;
   endfunction

   function automatic int build_codes();
      int present, nxt, a, b, c;
      for (int i = 0; i < 256; i++) begin
         table_len[i] = 0;
         table_bits[i] = 0;
      end
      heap_n = 0;
      for (int i = 0; i < 256; i++)
         if (counts[i] != 0) begin
            weight[i] = counts[i];
            heap[heap_n++] = i;
         end
      present = heap_n;
      if (present == 0) return 0;
      for (int i = (heap_n - 1) / 2; i >= 0; i--) sift_down(i);
      if (present == 1) begin
         table_len[heap[0]] = 6'd1;
         heap_n = 0;
         return 1;
      end
      nxt = 256;
      while (heap_n > 1) begin
         a = pop_min();
         b = pop_min();
         weight[nxt] = weight[a] + weight[b];
         kids[nxt][0] = a;
         kids[nxt][1] = b;
         push_node(nxt);
         nxt++;
      end
      heap_n = 0;
      walk_len[nxt - 1] = 0;
      walk_bits[nxt - 1] = 0;
      for (int n = nxt - 1; n >= 256; n--)
         for (int s = 0; s < 2; s++) begin
            c = kids[n][s];
            walk_len[c] = walk_len[n] + 1;
            walk_bits[c] = (walk_bits[n] << 1) | longint'(s);
            if (c < 256 && walk_len[c] <= MaxLen) begin
               table_len[c] = 6'(walk_len[c]);
               table_bits[c] = walk_bits[c][47:0];
            end
         end
      return present;
   endfunction

   function automatic void predict_item(item_type it);
      code_type e;
      case (it.op)
         OP_WRITE: counts[it.sym] = it.cnt;
         OP_BUILD: begin
            e.sym = 0; e.len = 0; e.bits = 0;
            e.distinct = 9'(build_codes());
            expected_codes.push_back(e);
         end
         OP_READ: begin
            e.sym = it.sym; e.len = table_len[it.sym];
            e.bits = table_bits[it.sym]; e.distinct = 0;
            expected_codes.push_back(e);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("error: %s got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) begin
            predict_item(cur);
            accepted++;
         end
         if (!(start && busy)) begin
            case ((accepted / 120) % 4)
               1: idle_pct = 58;
               3: idle_pct = 6;
               default: idle_pct = 0;
            endcase
            launch = 0;
            if (pending_items.size() > 0 && pending_items[0].drain) begin
               if (expected_codes.size() == 0) void'(pending_items.pop_front());
            end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               launch = 1;
            end
            if (launch) begin
               cur = pending_items.pop_front();
               req_operation <= cur.op;
               req_symbol <= cur.sym;
               req_count <= cur.cnt;
            end
            start <= launch;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_codes.size() == 0) begin
            report_mismatch("unexpected item", rsp_code_symbol, 0);
         end else begin
            code_type e;
            e = expected_codes.pop_front();
            if (rsp_code_symbol !== e.sym) report_mismatch("symbol", rsp_code_symbol, e.sym);
            if (rsp_code_length !== e.len) report_mismatch("length", rsp_code_length, e.len);
            if (rsp_code_bits !== e.bits) report_mismatch("bits", rsp_code_bits, e.bits);
            if (rsp_distinct_symbols !== e.distinct)
               report_mismatch("distinct", rsp_distinct_symbols, e.distinct);
         end
      end
   end

   task automatic add(op_type op, int sym, logic [23:0] cnt);
      item_type it;
      it.op = op; it.sym = 8'(sym); it.cnt = cnt; it.drain = 0;
      if (op == OP_WRITE) gen_counts[sym] = cnt;
      pending_items.push_back(it);
      total++;
   endtask

   task automatic wipe();
      for (int s = 0; s < 256; s++)
         if (gen_counts[s] != 0) add(OP_WRITE, s, 0);
   endtask

   function automatic logic [23:0] rand_count();
      case ($urandom_range(3))
         0: return 24'($urandom & 32'h3);
         1: return 24'($urandom & 32'hF);
         2: return 24'($urandom & 32'hFF);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_read();
      int s;
      s = $urandom_range(255);
      for (int j = 0; j < 256 && $urandom_range(9) < 7; j++)
         if (gen_counts[(s + j) % 256] != 0) begin
            s = (s + j) % 256;
            break;
         end
      add(OP_READ, s, 24'($urandom));
   endtask

   initial begin
      int nz;
      bit full_done, fib_done, drain_done;
      longint unsigned f0, f1, f2;
      item_type marker;
      for (int i = 0; i < 256; i++) begin
         counts[i] = 0; gen_counts[i] = 0; table_len[i] = 0; table_bits[i] = 0;
      end
      full_done = 0; fib_done = 0; drain_done = 0;

      // directed
      add(OP_READ, 0, 0);
      add(OP_BUILD, 0, 0);
      add(OP_READ, 255, 24'hFFFFFF);
      add(OP_WRITE, 255, 24'hFFFFFF);
      add(OP_BUILD, 0, 0);
      add(OP_READ, 255, 0);
      add(OP_READ, 0, 0);
      add(OP_WRITE, 0, 1);
      add(OP_NONE, 7, 24'h123456);
      add(OP_BUILD, 0, 0);
      add(OP_READ, 0, 0);
      add(OP_READ, 255, 0);
      add(OP_WRITE, 255, 0);
      for (int s = 1; s <= 4; s++) add(OP_WRITE, s * 40, 5);
      add(OP_BUILD, 0, 0);
      for (int s = 0; s <= 4; s++) add(OP_READ, s * 40, 0);
      add(OP_READ, 255, 0);

      while (total < 1050) begin
         nz = 0;
         foreach (gen_counts[s]) if (gen_counts[s] != 0) nz++;
         if (nz > 10) wipe();
         if (!fib_done && total > 200) begin
            // fibonacci weights give the deepest tree
            f0 = 1; f1 = 1;
            for (int s = 0; s < 36; s++) begin
               add(OP_WRITE, 10 + s * 6, f0[23:0]);
               f2 = f0 + f1; f0 = f1; f1 = f2;
            end
            add(OP_BUILD, 0, 0);
            for (int s = 0; s < 36; s += 5) add(OP_READ, 10 + s * 6, 0);
            add(OP_READ, 10 + 35 * 6, 0);
            wipe();
            fib_done = 1;
         end else if (!full_done && total > 400) begin
            for (int s = 0; s < 256; s++)
               add(OP_WRITE, s, 24'(($urandom & 32'hFFF) | 32'h1));
            add(OP_BUILD, 0, 0);
            repeat (12) add(OP_READ, $urandom_range(255), 0);
            wipe();
            full_done = 1;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(19) == 0) add(OP_NONE, $urandom, 24'($urandom));
               else add(OP_WRITE, $urandom_range(255), rand_count());
            end
            if ($urandom_range(9) == 0) random_read();
            add(OP_BUILD, 0, 0);
            repeat ($urandom_range(1, 6)) random_read();
         end
         if (!drain_done && total > 600) begin
            marker.drain = 1; marker.op = OP_NONE; marker.sym = 0; marker.cnt = 0;
            pending_items.push_back(marker);
            drain_done = 1;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 0;
      do @(posedge clock);
      while (pending_items.size() > 0 || start || busy || expected_codes.size() > 0);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("huffman_code_table_builder_core: match");
      else
         $display("huffman_code_table_builder_core: mismatch");
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("huffman_code_table_builder_core: mismatch");
      $finish;
   end

endmodule
